### rtl/core/fbas_pkg.sv
`default_nettype none

package fbas_pkg;

    // Function codes of an input word.
    typedef enum logic [1:0] {
        FUNC_MSG   = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_REPLY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_POLL_LIMIT = 2'd0;
    localparam logic [1:0] REG_NAK_CODE   = 2'd1;
    localparam logic [1:0] REG_FLAG_BYTE  = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] POLL_LIMIT_RST = 8'd10;
    localparam logic [7:0] NAK_CODE_RST   = 8'd85;
    localparam logic [7:0] FLAG_BYTE_RST  = 8'd126;

    // Byte positions within a frame.
    localparam logic [2:0] POS_FLAG_OPEN  = 3'd0;
    localparam logic [2:0] POS_SEQ        = 3'd1;
    localparam logic [2:0] POS_DATA       = 3'd2;
    localparam logic [2:0] POS_CHECK      = 3'd3;
    localparam logic [2:0] POS_FLAG_CLOSE = 3'd4;

    // Check byte arithmetic: (s * 256) mod 135 with 256 mod 135 = 121,
    // quotient estimated with a scaled reciprocal of 135.
    localparam int unsigned CHK_MODULUS  = 135;
    localparam int unsigned CHK_FACTOR   = 121;
    localparam int unsigned CHK_RECIP    = 15534;
    localparam int unsigned CHK_SHIFT    = 21;

    typedef struct packed {
        logic [7:0] poll_limit;
        logic [7:0] nak_code;
        logic [7:0] flag_byte;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_done;
        logic       busy_res;
        logic       rejected;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/fbas_check.sv
`default_nettype none

// Three-stage check byte unit. Loaded with a message byte, it works the check
// byte through the p1, p2/q2 and check registers in turn, then holds it at its output.
module fbas_check
    import fbas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       load,
    input  wire logic [7:0] data,
    output logic      [7:0] check_byte
);

    logic [7:0]  mag;
    logic [14:0] prod1;
    logic [28:0] prod2;
    logic [14:0] qmul;
    logic [14:0] rem_raw;
    logic [14:0] rem_fix;

    logic [14:0] p1_reg;
    logic        neg1_reg;
    logic [14:0] p2_reg;
    logic [7:0]  q2_reg;
    logic        neg2_reg;
    logic [7:0]  check_reg;
    logic [7:0]  check_next;

    always_comb begin
        mag     = data[7] ? 8'(9'd256 - {1'b0, data}) : data;
        prod1   = 15'({7'd0, mag} * 15'(CHK_FACTOR));
        prod2   = 29'({14'd0, p1_reg} * 29'(CHK_RECIP));
        qmul    = 15'({7'd0, q2_reg} * 15'(CHK_MODULUS));
        rem_raw = p2_reg - qmul;
        rem_fix = (rem_raw >= 15'(CHK_MODULUS)) ? rem_raw - 15'(CHK_MODULUS) : rem_raw;
        // A negative byte gives a negative remainder under truncation.
        check_next = neg2_reg ? 8'(8'd0 - rem_fix[7:0]) : rem_fix[7:0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            p1_reg   <= prod1;
            neg1_reg <= data[7];
        end
        p2_reg    <= p1_reg;
        neg2_reg  <= neg1_reg;
        q2_reg    <= prod2[28:CHK_SHIFT];
        check_reg <= check_next;
    end

    assign check_byte = check_reg;

endmodule

`default_nettype wire

### rtl/core/fbas_ctrl.sv
`default_nettype none

// Frame sender state and the result of each accepted word.
module fbas_ctrl
    import fbas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [1:0] func,
    input  wire logic [7:0] data,
    input  wire logic       msg_last,
    input  wire cfg_t       cfg,
    input  wire logic [7:0] check_byte,
    output logic            load_check,
    output result_t         res_next
);

    logic       active_reg,       active_next;
    logic [2:0] position_reg,     position_next;
    logic [7:0] held_data_reg,    held_data_next;
    logic [7:0] sequence_reg,     sequence_next;
    logic       last_of_msg_reg,  last_of_msg_next;
    logic [7:0] tick_count_reg,   tick_count_next;
    logic       check_failed_reg, check_failed_next;

    logic [8:0] tick_inc;
    logic [2:0] pos_inc;
    logic       failed_now;

    function automatic logic [7:0] byte_at(
        input logic [2:0] pos,
        input logic [7:0] flag,
        input logic [7:0] seq,
        input logic [7:0] held,
        input logic [7:0] chk
    );
        logic [7:0] b;
        case (pos)
            POS_FLAG_OPEN: b = flag;
            POS_SEQ:       b = seq;
            POS_DATA:      b = held;
            POS_CHECK:     b = chk;
            default:       b = flag;
        endcase
        return b;
    endfunction

    always_comb begin
        active_next       = active_reg;
        position_next     = position_reg;
        held_data_next    = held_data_reg;
        sequence_next     = sequence_reg;
        last_of_msg_next  = last_of_msg_reg;
        tick_count_next   = tick_count_reg;
        check_failed_next = check_failed_reg;
        load_check        = 1'b0;
        res_next          = '0;

        tick_inc   = {1'b0, tick_count_reg} + 9'd1;
        pos_inc    = position_reg + 3'd1;
        failed_now = check_failed_reg
                     || ((position_reg == POS_CHECK) && (data == cfg.nak_code));

        case (func_t'(func))
            FUNC_MSG: begin
                if (active_reg) begin
                    res_next.rejected = 1'b1;
                end else begin
                    active_next       = 1'b1;
                    position_next     = POS_FLAG_OPEN;
                    held_data_next    = data;
                    last_of_msg_next  = msg_last;
                    tick_count_next   = '0;
                    check_failed_next = 1'b0;
                    load_check        = accept;
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = cfg.flag_byte;
                end
            end
            FUNC_TICK: begin
                if (active_reg) begin
                    if (tick_inc >= {1'b0, cfg.poll_limit}) begin
                        tick_count_next   = '0;
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = byte_at(position_reg, cfg.flag_byte,
                                                    sequence_reg, held_data_reg,
                                                    check_byte);
                    end else begin
                        tick_count_next = tick_inc[7:0];
                    end
                end
            end
            FUNC_REPLY: begin
                if (active_reg && (data != 8'd0)) begin
                    tick_count_next   = '0;
                    check_failed_next = failed_now;
                    if (position_reg >= POS_FLAG_CLOSE) begin
                        position_next = POS_FLAG_OPEN;
                        if (failed_now) begin
                            check_failed_next = 1'b0;
                            res_next.tx_valid = 1'b1;
                            res_next.tx_byte  = cfg.flag_byte;
                        end else begin
                            active_next         = 1'b0;
                            res_next.frame_done = 1'b1;
                            sequence_next       = last_of_msg_reg ? 8'd0
                                                                  : sequence_reg + 8'd1;
                        end
                    end else begin
                        position_next     = pos_inc;
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = byte_at(pos_inc, cfg.flag_byte,
                                                    sequence_reg, held_data_reg,
                                                    check_byte);
                    end
                end
            end
            default: begin
            end
        endcase

        res_next.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            position_reg     <= POS_FLAG_OPEN;
            held_data_reg    <= '0;
            sequence_reg     <= '0;
            last_of_msg_reg  <= 1'b0;
            tick_count_reg   <= '0;
            check_failed_reg <= 1'b0;
        end else if (accept) begin
            active_reg       <= active_next;
            position_reg     <= position_next;
            held_data_reg    <= held_data_next;
            sequence_reg     <= sequence_next;
            last_of_msg_reg  <= last_of_msg_next;
            tick_count_reg   <= tick_count_next;
            check_failed_reg <= check_failed_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/framed_byte_ack_sender.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_func, s_data, s_msg_last
// m_        out        m_valid / m_ready  m_tx_valid, m_tx_byte, m_frame_done,
//                                         m_busy_res, m_rejected
// cfg_wr_   in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// Every accepted word yields exactly one result word, in the cycle after it is accepted.
// A new word can be accepted in every cycle; the result register frees itself
// in the same cycle its word is taken, so s_ready only drops while a result
// waits on a low m_ready or while reset is held.
// Reset is synchronous on aresetn low: the frame state clears and the
// configuration returns to its defaults (poll limit 10, NAK 0x55, flag 0x7E).
module framed_byte_ack_sender
    import fbas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [7:0] s_data,
    input  wire logic       s_msg_last,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_tx_valid,
    output logic      [7:0] m_tx_byte,
    output logic            m_frame_done,
    output logic            m_busy_res,
    output logic            m_rejected,

    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_index,
    input  wire logic [7:0] cfg_wr_data
);

    cfg_t    cfg_reg;
    logic    m_valid_reg;
    result_t result_reg;
    result_t res_next;
    logic    accept;
    logic    load_check;
    logic [7:0] check_byte;

    // The result register is free when empty or when its word leaves now.
    // No word is taken while reset is held, since the state would drop it.
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Configuration registers. Writes to an unused index are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_limit <= POLL_LIMIT_RST;
            cfg_reg.nak_code   <= NAK_CODE_RST;
            cfg_reg.flag_byte  <= FLAG_BYTE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_POLL_LIMIT: cfg_reg.poll_limit <= cfg_wr_data;
                REG_NAK_CODE:   cfg_reg.nak_code   <= cfg_wr_data;
                REG_FLAG_BYTE:  cfg_reg.flag_byte  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // The check byte is worked out in the background while the opening
    // flag, sequence number and data byte are on their way; it is needed
    // no earlier than the third word after the message byte.
    fbas_check u_check (
        .aclk       (aclk),
        .load       (load_check),
        .data       (s_data),
        .check_byte (check_byte)
    );

    fbas_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .func       (s_func),
        .data       (s_data),
        .msg_last   (s_msg_last),
        .cfg        (cfg_reg),
        .check_byte (check_byte),
        .load_check (load_check),
        .res_next   (res_next)
    );

    // Result register: holds the word until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tx_valid   = result_reg.tx_valid;
    assign m_tx_byte    = result_reg.tx_byte;
    assign m_frame_done = result_reg.frame_done;
    assign m_busy_res   = result_reg.busy_res;
    assign m_rejected   = result_reg.rejected;

endmodule

`default_nettype wire

### rtl/core/fbas_checker.sv
`default_nettype none

module fbas_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_tx_valid,
    input wire logic [7:0] m_tx_byte,
    input wire logic       m_frame_done,
    input wire logic       m_busy_res,
    input wire logic       m_rejected
);

    // A stalled result word stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_busy_res))
        else $error("stalled result word changed");

    // Nothing transmitted means a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_byte == 8'd0)
        else $error("tx byte nonzero without transmit");

    // A finished frame leaves the sender idle and sends nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_busy_res && !m_tx_valid && !m_rejected)
        else $error("frame done while still busy or sending");

    // A rejected message byte is only seen while a frame is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res && !m_tx_valid)
        else $error("rejection while idle or with a transmit");

    // Every accepted word produces a result word in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");

endmodule

bind framed_byte_ack_sender fbas_checker u_fbas_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_tx_valid   (m_tx_valid),
    .m_tx_byte    (m_tx_byte),
    .m_frame_done (m_frame_done),
    .m_busy_res   (m_busy_res),
    .m_rejected   (m_rejected)
);

`default_nettype wire
